// ===== rtl/phfe_pkg.sv =====
// ----------------------------------------------------------------------------
// phfe_pkg: shared types and constants of the header field extractor
// Field tags, network kinds, header offsets and the record pair that the
// parser hands to the output side through the queue.
// ----------------------------------------------------------------------------
package phfe_pkg;

  // defaults for the top level parameters
  localparam int MAX_FRAME_BYTES_DEF = 65535;
  localparam int QUEUE_DEPTH_DEF     = 4;

  // payload byte display
  localparam logic [3:0] SHOW_CAP   = 4'd10;
  localparam logic [3:0] SHOW_RESET = 4'd10;

  // ethernet header
  localparam logic [15:0] OFF_DST_MAC_LAST = 16'd5;
  localparam logic [15:0] OFF_SRC_MAC_LAST = 16'd11;
  localparam logic [15:0] OFF_ETYPE_LAST   = 16'd13;
  localparam logic [15:0] L3_BASE          = 16'd14;
  localparam logic [15:0] ETYPE_V4         = 16'h0800;
  localparam logic [15:0] ETYPE_V6         = 16'h86DD;
  localparam logic [7:0]  PROTO_TCP        = 8'd6;
  localparam logic [7:0]  PROTO_UDP        = 8'd17;

  // offsets inside the ipv4 header
  localparam logic [15:0] R_V4_IHL   = 16'd0;
  localparam logic [15:0] R_V4_TLEN  = 16'd3;
  localparam logic [15:0] R_V4_PROTO = 16'd9;
  localparam logic [15:0] R_V4_TAG   = 16'd10;
  localparam logic [15:0] R_V4_SRC   = 16'd15;
  localparam logic [15:0] R_V4_DST   = 16'd19;

  // offsets inside the ipv6 header
  localparam logic [15:0] R_V6_PLEN   = 16'd5;
  localparam logic [15:0] R_V6_NEXT   = 16'd6;
  localparam logic [15:0] R_V6_TAG    = 16'd7;
  localparam logic [15:0] R_V6_SRC_HI = 16'd15;
  localparam logic [15:0] R_V6_SRC_LO = 16'd23;
  localparam logic [15:0] R_V6_DST_HI = 16'd31;
  localparam logic [15:0] R_V6_DST_LO = 16'd39;

  // offsets inside the l4 header
  localparam logic [15:0] Q_SPORT_LAST = 16'd1;
  localparam logic [15:0] Q_DPORT_LAST = 16'd3;
  localparam logic [15:0] Q_TCP_DOFF   = 16'd12;

  // last offsets a complete frame must reach, header starts
  localparam logic [7:0] NEED_RESET    = 8'd13;
  localparam logic [7:0] NEED_V4_PROTO = 8'd23;
  localparam logic [7:0] NEED_V6_NEXT  = 8'd20;
  localparam logic [7:0] NEED_L3_TAG   = 8'd14;
  localparam logic [7:0] V4_L3_LAST    = 8'd33;
  localparam logic [7:0] V6_L3_LAST    = 8'd53;
  localparam logic [7:0] V6_L4_START   = 8'd54;
  localparam logic [7:0] UDP_NEED_ADD  = 8'd3;
  localparam logic [7:0] TCP_NEED_ADD  = 8'd12;

  typedef enum logic [1:0] {
    NET_NONE,
    NET_V4,
    NET_V6,
    NET_OTHER
  } net_kind_t;

  typedef enum logic [4:0] {
    KIND_DST_MAC,
    KIND_SRC_MAC,
    KIND_ETHERTYPE,
    KIND_V4_SRC,
    KIND_V4_DST,
    KIND_V6_SRC_HI,
    KIND_V6_SRC_LO,
    KIND_V6_DST_HI,
    KIND_V6_DST_LO,
    KIND_L4_PROTO,
    KIND_TCP_SPORT,
    KIND_TCP_DPORT,
    KIND_UDP_SPORT,
    KIND_UDP_DPORT,
    KIND_PAY_LEN,
    KIND_PAY_BYTE,
    KIND_L3_UNSUP,
    KIND_L4_UNSUP,
    KIND_DONE
  } field_kind_t;

  // what one input beat produces: at most one field and one closing record
  typedef struct packed {
    logic        fld_vld;
    field_kind_t kind;
    logic [63:0] value;
    logic        done_vld;
    logic        trunc;
  } rec_pair_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_status_t;

endpackage

// ===== rtl/phfe_if.sv =====
// ----------------------------------------------------------------------------
// phfe_if: stream channels of the header field extractor
// Byte channel into the parser and field record channel out of the block.
// ----------------------------------------------------------------------------
interface phfe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface phfe_field_if;
  logic        valid;
  logic        ready;
  logic [4:0]  field_kind;
  logic [63:0] field_value;
  logic        last_of_frame;

  modport source (output valid, output field_kind, output field_value,
                  output last_of_frame, input ready);
  modport sink   (input valid, input field_kind, input field_value,
                  input last_of_frame, output ready);
endinterface

// ===== rtl/phfe_front.sv =====
// ----------------------------------------------------------------------------
// phfe_front: byte parser
// Tracks offset and header lengths, shifts bytes into a 64-bit field register
// and pushes the records each byte completes into the queue.
// ----------------------------------------------------------------------------
module phfe_front #(
  parameter int MAX_FRAME_BYTES = phfe_pkg::MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wen,
  input  logic [3:0]           cfg_wdata,
  phfe_byte_if.sink            byte_in,
  input  phfe_pkg::q_status_t  q_stat,
  output logic                 q_push,
  output phfe_pkg::rec_pair_t  q_data
);
  import phfe_pkg::*;

  localparam int OFF_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam logic [OFF_W-1:0] OFF_MAX = OFF_W'(MAX_FRAME_BYTES);

  logic [3:0]       payload_bytes_shown;
  logic [OFF_W-1:0] byte_offset, byte_offset_next;
  logic [63:0]      field_shift, field_shift_next;
  net_kind_t        network_kind, network_kind_next;
  logic [7:0]       l4_start, l4_start_next;
  logic [7:0]       transport_proto, transport_proto_next;
  logic [15:0]      remaining_length, remaining_length_next;
  logic [7:0]       payload_start, payload_start_next;
  logic [3:0]       bytes_shown, bytes_shown_next;
  logic [7:0]       need_until, need_until_next, need_parsed;
  logic [3:0]       show_limit, show_limit_next;

  logic        accept;
  logic        parse_en;
  logic [7:0]  b;
  logic [63:0] sh;
  logic [15:0] off16, r, q;
  logic [3:0]  ihl_eff, doff_eff;
  logic [7:0]  v4_hl, tcp_hl, v4_hl_reg;
  logic [15:0] plen;
  logic [3:0]  cap, lim;
  logic [7:0]  pstart_calc;
  logic        proto_ok;
  logic        fld_vld;
  field_kind_t fld_kind;
  logic [63:0] fld_value;

  assign byte_in.ready = !q_stat.full;
  assign accept        = byte_in.valid && byte_in.ready;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_bytes_shown <= SHOW_RESET;
    end else if (cfg_wen) begin
      payload_bytes_shown <= cfg_wdata;
    end
  end

  // shared datapath terms
  always_comb begin
    b           = byte_in.frame_byte;
    sh          = {field_shift[55:0], b};
    off16       = 16'(byte_offset);
    r           = off16 - L3_BASE;
    q           = off16 - {8'd0, l4_start};
    parse_en    = byte_offset < OFF_MAX;
    ihl_eff     = (b[3:0] < 4'd5) ? 4'd5 : b[3:0];
    doff_eff    = (b[7:4] < 4'd5) ? 4'd5 : b[7:4];
    v4_hl       = {2'b00, ihl_eff, 2'b00};
    tcp_hl      = {2'b00, doff_eff, 2'b00};
    v4_hl_reg   = l4_start - L3_BASE[7:0];
    plen        = (remaining_length > {8'd0, tcp_hl}) ?
                  remaining_length - {8'd0, tcp_hl} : 16'd0;
    cap         = (payload_bytes_shown > SHOW_CAP) ? SHOW_CAP : payload_bytes_shown;
    lim         = (plen < {12'd0, cap}) ? plen[3:0] : cap;
    pstart_calc = l4_start + tcp_hl;
    proto_ok    = (transport_proto == PROTO_TCP) || (transport_proto == PROTO_UDP);
  end

  // per byte parse
  always_comb begin
    byte_offset_next      = byte_offset;
    field_shift_next      = field_shift;
    network_kind_next     = network_kind;
    l4_start_next         = l4_start;
    transport_proto_next  = transport_proto;
    remaining_length_next = remaining_length;
    payload_start_next    = payload_start;
    bytes_shown_next      = bytes_shown;
    need_parsed           = need_until;
    show_limit_next       = show_limit;
    fld_vld               = 1'b0;
    fld_kind              = KIND_DST_MAC;
    fld_value             = '0;

    if (parse_en) begin
      field_shift_next = sh;
      byte_offset_next = byte_offset + OFF_W'(1);
      if (off16 == OFF_DST_MAC_LAST) begin
        fld_vld   = 1'b1;
        fld_kind  = KIND_DST_MAC;
        fld_value = {16'd0, sh[47:0]};
      end else if (off16 == OFF_SRC_MAC_LAST) begin
        fld_vld   = 1'b1;
        fld_kind  = KIND_SRC_MAC;
        fld_value = {16'd0, sh[47:0]};
      end else if (off16 == OFF_ETYPE_LAST) begin
        fld_vld   = 1'b1;
        fld_kind  = KIND_ETHERTYPE;
        fld_value = {48'd0, sh[15:0]};
        if (sh[15:0] == ETYPE_V4) begin
          network_kind_next = NET_V4;
          need_parsed       = NEED_V4_PROTO;
        end else if (sh[15:0] == ETYPE_V6) begin
          network_kind_next = NET_V6;
          l4_start_next     = V6_L4_START;
          need_parsed       = NEED_V6_NEXT;
        end else begin
          network_kind_next = NET_OTHER;
          need_parsed       = NEED_L3_TAG;
        end
      end else if (off16 >= L3_BASE) begin
        if (network_kind == NET_OTHER) begin
          // unsupported l3 tag one byte after the ethertype
          if (off16 == L3_BASE) begin
            fld_vld   = 1'b1;
            fld_kind  = KIND_L3_UNSUP;
            fld_value = {48'd0, sh[23:8]};
          end
        end else if (l4_start != 8'd0 && off16 >= {8'd0, l4_start}) begin
          // transport header and payload
          if (transport_proto == PROTO_TCP) begin
            if (q == Q_SPORT_LAST) begin
              fld_vld   = 1'b1;
              fld_kind  = KIND_TCP_SPORT;
              fld_value = {48'd0, sh[15:0]};
            end else if (q == Q_DPORT_LAST) begin
              fld_vld   = 1'b1;
              fld_kind  = KIND_TCP_DPORT;
              fld_value = {48'd0, sh[15:0]};
            end else if (q == Q_TCP_DOFF) begin
              payload_start_next = pstart_calc;
              fld_vld            = 1'b1;
              fld_kind           = KIND_PAY_LEN;
              fld_value          = {48'd0, plen};
              show_limit_next    = lim;
              if (lim != 4'd0) begin
                need_parsed = pstart_calc + {4'd0, lim} - 8'd1;
              end
            end else if (q > Q_TCP_DOFF && off16 >= {8'd0, payload_start} &&
                         bytes_shown < show_limit) begin
              fld_vld          = 1'b1;
              fld_kind         = KIND_PAY_BYTE;
              fld_value        = {56'd0, b};
              bytes_shown_next = bytes_shown + 4'd1;
            end
          end else if (transport_proto == PROTO_UDP) begin
            if (q == Q_SPORT_LAST) begin
              fld_vld   = 1'b1;
              fld_kind  = KIND_UDP_SPORT;
              fld_value = {48'd0, sh[15:0]};
            end else if (q == Q_DPORT_LAST) begin
              fld_vld   = 1'b1;
              fld_kind  = KIND_UDP_DPORT;
              fld_value = {48'd0, sh[15:0]};
            end
          end
        end else begin
          // network header
          case (network_kind)
            NET_V4: begin
              case (r)
                R_V4_IHL: begin
                  l4_start_next = L3_BASE[7:0] + v4_hl;
                end
                R_V4_TLEN: begin
                  remaining_length_next = (sh[15:0] > {8'd0, v4_hl_reg}) ?
                                          sh[15:0] - {8'd0, v4_hl_reg} : 16'd0;
                end
                R_V4_PROTO: begin
                  transport_proto_next = b;
                  fld_vld              = 1'b1;
                  fld_kind             = KIND_L4_PROTO;
                  fld_value            = {56'd0, b};
                  if (b == PROTO_TCP) begin
                    need_parsed = l4_start + TCP_NEED_ADD;
                  end else if (b == PROTO_UDP) begin
                    need_parsed = l4_start + UDP_NEED_ADD;
                  end else begin
                    need_parsed = V4_L3_LAST;
                  end
                end
                R_V4_TAG: begin
                  if (!proto_ok) begin
                    fld_vld   = 1'b1;
                    fld_kind  = KIND_L4_UNSUP;
                    fld_value = {56'd0, transport_proto};
                  end
                end
                R_V4_SRC: begin
                  fld_vld   = 1'b1;
                  fld_kind  = KIND_V4_SRC;
                  fld_value = {32'd0, sh[31:0]};
                end
                R_V4_DST: begin
                  fld_vld   = 1'b1;
                  fld_kind  = KIND_V4_DST;
                  fld_value = {32'd0, sh[31:0]};
                end
                default: begin
                end
              endcase
            end
            NET_V6: begin
              case (r)
                R_V6_PLEN: begin
                  remaining_length_next = sh[15:0];
                end
                R_V6_NEXT: begin
                  transport_proto_next = b;
                  fld_vld              = 1'b1;
                  fld_kind             = KIND_L4_PROTO;
                  fld_value            = {56'd0, b};
                  if (b == PROTO_TCP) begin
                    need_parsed = l4_start + TCP_NEED_ADD;
                  end else if (b == PROTO_UDP) begin
                    need_parsed = l4_start + UDP_NEED_ADD;
                  end else begin
                    need_parsed = V6_L3_LAST;
                  end
                end
                R_V6_TAG: begin
                  if (!proto_ok) begin
                    fld_vld   = 1'b1;
                    fld_kind  = KIND_L4_UNSUP;
                    fld_value = {56'd0, transport_proto};
                  end
                end
                R_V6_SRC_HI: begin
                  fld_vld   = 1'b1;
                  fld_kind  = KIND_V6_SRC_HI;
                  fld_value = sh;
                end
                R_V6_SRC_LO: begin
                  fld_vld   = 1'b1;
                  fld_kind  = KIND_V6_SRC_LO;
                  fld_value = sh;
                end
                R_V6_DST_HI: begin
                  fld_vld   = 1'b1;
                  fld_kind  = KIND_V6_DST_HI;
                  fld_value = sh;
                end
                R_V6_DST_LO: begin
                  fld_vld   = 1'b1;
                  fld_kind  = KIND_V6_DST_LO;
                  fld_value = sh;
                end
                default: begin
                end
              endcase
            end
            default: begin
            end
          endcase
        end
      end
    end

    need_until_next = need_parsed;

    // frame end clears all per frame state
    if (byte_in.frame_end) begin
      byte_offset_next      = '0;
      field_shift_next      = '0;
      network_kind_next     = NET_NONE;
      l4_start_next         = '0;
      transport_proto_next  = '0;
      remaining_length_next = '0;
      payload_start_next    = '0;
      bytes_shown_next      = '0;
      need_until_next       = NEED_RESET;
      show_limit_next       = '0;
    end
  end

  // queue push
  always_comb begin
    q_push         = accept && (fld_vld || byte_in.frame_end);
    q_data.fld_vld  = fld_vld;
    q_data.kind     = fld_kind;
    q_data.value    = fld_value;
    q_data.done_vld = byte_in.frame_end;
    q_data.trunc    = off16 < {8'd0, need_parsed};
  end

  // parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_offset      <= '0;
      field_shift      <= '0;
      network_kind     <= NET_NONE;
      l4_start         <= '0;
      transport_proto  <= '0;
      remaining_length <= '0;
      payload_start    <= '0;
      bytes_shown      <= '0;
      need_until       <= NEED_RESET;
      show_limit       <= '0;
    end else if (accept) begin
      byte_offset      <= byte_offset_next;
      field_shift      <= field_shift_next;
      network_kind     <= network_kind_next;
      l4_start         <= l4_start_next;
      transport_proto  <= transport_proto_next;
      remaining_length <= remaining_length_next;
      payload_start    <= payload_start_next;
      bytes_shown      <= bytes_shown_next;
      need_until       <= need_until_next;
      show_limit       <= show_limit_next;
    end
  end

endmodule

// ===== rtl/phfe_queue.sv =====
// ----------------------------------------------------------------------------
// phfe_queue: record pair queue
// Small register queue between the parser and the output side.
// ----------------------------------------------------------------------------
module phfe_queue #(
  parameter int QUEUE_DEPTH = phfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  phfe_pkg::rec_pair_t  push_data,
  input  logic                 pop,
  output phfe_pkg::rec_pair_t  head,
  output phfe_pkg::q_status_t  stat
);
  import phfe_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  rec_pair_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head           = entries[rd_ptr];
  assign stat.not_empty = count != '0;
  assign stat.full      = count == CNT_FULL;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/phfe_back.sv =====
// ----------------------------------------------------------------------------
// phfe_back: record serializer
// Splits each queued pair into single records and holds them in the output
// register until the receiver takes them.
// ----------------------------------------------------------------------------
module phfe_back (
  input  logic                 clk,
  input  logic                 rst,
  input  phfe_pkg::rec_pair_t  head,
  input  phfe_pkg::q_status_t  q_stat,
  output logic                 q_pop,
  phfe_field_if.source         field_out
);
  import phfe_pkg::*;

  logic        out_valid;
  field_kind_t out_kind;
  logic [63:0] out_value;
  logic        out_last;
  logic        half, half_next;
  logic        load;
  logic        emit_fld;

  assign field_out.valid         = out_valid;
  assign field_out.field_kind    = out_kind;
  assign field_out.field_value   = out_value;
  assign field_out.last_of_frame = out_last;

  // pick the next record from the head pair
  always_comb begin
    load      = q_stat.not_empty && (!out_valid || field_out.ready);
    emit_fld  = head.fld_vld && !half;
    q_pop     = load && !(emit_fld && head.done_vld);
    half_next = load ? (emit_fld && head.done_vld) : half;
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      half      <= 1'b0;
    end else begin
      half <= half_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (field_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (load) begin
      if (emit_fld) begin
        out_kind  <= head.kind;
        out_value <= head.value;
        out_last  <= 1'b0;
      end else begin
        out_kind  <= KIND_DONE;
        out_value <= {63'd0, head.trunc};
        out_last  <= 1'b1;
      end
    end
  end

endmodule

// ===== rtl/packet_header_field_extractor_top.sv =====
// ----------------------------------------------------------------------------
// packet_header_field_extractor_top: ethernet/ip/tcp/udp header field parser
// Takes a frame one byte per beat and returns tagged header field records.
// ----------------------------------------------------------------------------
// byte_in carries frame_byte and frame_end (set on the last byte of a frame).
// field_out carries field_kind, field_value and last_of_frame; every frame
// closes with a done record whose value is 1 when the frame was truncated.
// cfg_wen/cfg_wdata write the count of leading tcp payload bytes shown; write
// it only while no frame is in flight.
// Throughput: one byte per cycle while the queue is not full, set by the
// byte parser, which handles each byte combinationally. Output side moves
// one record per cycle while the receiver is ready; a byte that closes a
// field and ends the frame gives two records, the field record first.
// Each record passes through a queue entry, then the output register.
// Reset: parser state clears, the queue empties, the payload byte count
// returns to ten and byte_in.ready rises.
// Stall: a stalled record holds in the output register; the parser keeps
// taking bytes until the queue fills, then byte_in.ready drops.
// ----------------------------------------------------------------------------
module packet_header_field_extractor_top #(
  parameter int MAX_FRAME_BYTES = phfe_pkg::MAX_FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH     = phfe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wen,
  input  logic [3:0]   cfg_wdata,
  phfe_byte_if.sink    byte_in,
  phfe_field_if.source field_out
);
  import phfe_pkg::*;

  logic      q_push;
  logic      q_pop;
  rec_pair_t q_data;
  rec_pair_t q_head;
  q_status_t q_stat;

  // byte parser
  phfe_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .byte_in   (byte_in),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_data    (q_data)
  );

  // decoupling queue
  phfe_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // record serializer
  phfe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .field_out (field_out)
  );

endmodule

// ===== rtl/phfe_checker.sv =====
// ----------------------------------------------------------------------------
// phfe_checker: port level checks of the header field extractor
// Watches the top level channels and flags record or handshake slips.
// ----------------------------------------------------------------------------
module phfe_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [4:0]  out_kind,
  input logic [63:0] out_value,
  input logic        out_last
);
  import phfe_pkg::*;

  // empty after reset: no record, bytes taken
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("output valid or input stalled right after reset");

  // stalled record holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) &&
                                $stable(out_value) && $stable(out_last))
    else $error("stalled record changed");

  // last flag marks the done record only
  a_last_is_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last == (out_kind == KIND_DONE)))
    else $error("last_of_frame disagrees with done tag");

  // done record carries only the truncation bit
  a_done_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_last |-> out_value[63:1] == '0)
    else $error("done record value wider than one bit");

endmodule

bind packet_header_field_extractor_top phfe_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (byte_in.ready),
  .out_valid (field_out.valid),
  .out_ready (field_out.ready),
  .out_kind  (field_out.field_kind),
  .out_value (field_out.field_value),
  .out_last  (field_out.last_of_frame)
);
